@@ src/m4au_pkg.sv @@
// Types, constants and helpers shared by the matrix unit modules.
`default_nettype none
package m4au_pkg;

	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int TERM_W    = PROD_W - FRAC_BITS;
	localparam int ACC_W     = TERM_W + $clog2(DIM);
	localparam int IDX_W     = $clog2(DIM);

	localparam logic [1:0] OPC_LOAD_A = 2'd0;
	localparam logic [1:0] OPC_LOAD_B = 2'd1;
	localparam logic [1:0] OPC_RUN    = 2'd2;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_SUB    = 3'd1;
	localparam logic [2:0] OP_SCALE  = 3'd2;
	localparam logic [2:0] OP_MATMUL = 3'd3;
	localparam logic [2:0] OP_MATVEC = 3'd4;

	typedef logic [DIM-1:0][ELEM_W-1:0] col_t;

	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] k;
		logic [2:0]       op;
	} mac_ctl_t;

	function automatic logic signed [TERM_W-1:0] sext_term(input logic [ELEM_W-1:0] v);
		sext_term = {{(TERM_W - ELEM_W){v[ELEM_W-1]}}, v};
	endfunction

endpackage
`default_nettype wire

@@ src/m4au_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module m4au_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/m4au_mac.sv @@
// Four-lane shared multiply-accumulate unit with result clamping.
`default_nettype none
module m4au_mac (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire m4au_pkg::col_t     a_col,
	input  wire m4au_pkg::col_t     b_col,
	input  wire m4au_pkg::mac_ctl_t ctl_s1,
	output m4au_pkg::col_t          res,
	output logic                    sat,
	output logic                    done
);

	logic [m4au_pkg::ELEM_W-1:0]        b_sel  [m4au_pkg::DIM];
	logic signed [m4au_pkg::PROD_W-1:0] prod   [m4au_pkg::DIM];
	logic signed [m4au_pkg::PROD_W-1:0] prod_sh[m4au_pkg::DIM];
	logic signed [m4au_pkg::TERM_W-1:0] term   [m4au_pkg::DIM];
	logic signed [m4au_pkg::TERM_W-1:0] term_s2[m4au_pkg::DIM];
	logic signed [m4au_pkg::ACC_W-1:0]  acc_q  [m4au_pkg::DIM];
	logic [m4au_pkg::DIM-1:0]           lane_sat;
	m4au_pkg::mac_ctl_t                 ctl_s2;
	logic                               done_q;

	always_comb begin
		for (int r = 0; r < m4au_pkg::DIM; r++) begin
			case (ctl_s1.op)
				m4au_pkg::OP_SCALE: begin
					b_sel[r] = b_col[0];
				end
				m4au_pkg::OP_MATMUL, m4au_pkg::OP_MATVEC: begin
					b_sel[r] = b_col[ctl_s1.k];
				end
				default: begin
					b_sel[r] = b_col[r];
				end
			endcase
			prod[r]    = $signed(a_col[r]) * $signed(b_sel[r]);
			prod_sh[r] = prod[r] >>> m4au_pkg::FRAC_BITS;
			case (ctl_s1.op)
				m4au_pkg::OP_ADD: begin
					term[r] = m4au_pkg::sext_term(a_col[r]) + m4au_pkg::sext_term(b_col[r]);
				end
				m4au_pkg::OP_SUB: begin
					term[r] = m4au_pkg::sext_term(a_col[r]) - m4au_pkg::sext_term(b_col[r]);
				end
				default: begin
					term[r] = prod_sh[r][m4au_pkg::TERM_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < m4au_pkg::DIM; r++) begin
			term_s2[r] <= term[r];
			if (ctl_s2.valid) begin
				if (ctl_s2.first) begin
					acc_q[r] <= m4au_pkg::ACC_W'(term_s2[r]);
				end else begin
					acc_q[r] <= acc_q[r] + m4au_pkg::ACC_W'(term_s2[r]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_comb begin
		for (int r = 0; r < m4au_pkg::DIM; r++) begin
			if (!acc_q[r][m4au_pkg::ACC_W-1] &&
				(|acc_q[r][m4au_pkg::ACC_W-2:m4au_pkg::ELEM_W-1])) begin
				res[r]      = {1'b0, {(m4au_pkg::ELEM_W-1){1'b1}}};
				lane_sat[r] = 1'b1;
			end else if (acc_q[r][m4au_pkg::ACC_W-1] &&
				!(&acc_q[r][m4au_pkg::ACC_W-2:m4au_pkg::ELEM_W-1])) begin
				res[r]      = {1'b1, {(m4au_pkg::ELEM_W-1){1'b0}}};
				lane_sat[r] = 1'b1;
			end else begin
				res[r]      = acc_q[r][m4au_pkg::ELEM_W-1:0];
				lane_sat[r] = 1'b0;
			end
		end
	end

	assign sat  = |lane_sat;
	assign done = done_q;

endmodule
`default_nettype wire

@@ src/matrix4_arith_unit.sv @@
// Top level of the 4x4 fixed-point matrix unit: sequencer, operand stores and output register.
`default_nettype none
// A load beat writes one column of A or B. A run beat streams result
// columns through one four-lane multiply-accumulate unit fed by the two
// column stores: each column takes its issue steps (one for add, subtract
// and scale, four for the matrix and matrix-vector products), passes through
// store read, multiply, accumulate and clamp, and then waits until its result
// beat is taken. The input is stalled for the whole run.
module matrix4_arith_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 item_valid,
	output logic                                      item_stall,
	input  wire logic [1:0]                           opcode,
	input  wire logic [1:0]                           column_index,
	input  wire logic [2:0]                           operation,
	input  wire logic signed [m4au_pkg::ELEM_W-1:0]   elem_zero,
	input  wire logic signed [m4au_pkg::ELEM_W-1:0]   elem_one,
	input  wire logic signed [m4au_pkg::ELEM_W-1:0]   elem_two,
	input  wire logic signed [m4au_pkg::ELEM_W-1:0]   elem_three,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic [1:0]                                result_column,
	output logic signed [m4au_pkg::ELEM_W-1:0]        res_zero,
	output logic signed [m4au_pkg::ELEM_W-1:0]        res_one,
	output logic signed [m4au_pkg::ELEM_W-1:0]        res_two,
	output logic signed [m4au_pkg::ELEM_W-1:0]        res_three,
	output logic                                      saturated,
	output logic                                      last_column
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                       state_q;
	logic [2:0]                       op_q;
	logic [m4au_pkg::IDX_W-1:0]       col_q;
	logic [m4au_pkg::IDX_W-1:0]       k_q;
	m4au_pkg::mac_ctl_t               ctl_s1;
	m4au_pkg::mac_ctl_t               ctl_s0;
	logic                             accept;
	logic                             multi_step;
	logic                             step_last;
	logic                             run_last;
	logic                             we_a;
	logic                             we_b;
	m4au_pkg::col_t                   load_col;
	logic [m4au_pkg::IDX_W-1:0]       a_raddr;
	logic [m4au_pkg::IDX_W-1:0]       b_raddr;
	m4au_pkg::col_t                   a_col;
	m4au_pkg::col_t                   b_col;
	m4au_pkg::col_t                   mac_res;
	logic                             mac_sat;
	logic                             mac_done;
	logic                             out_valid_q;
	logic [m4au_pkg::IDX_W-1:0]       out_col_q;
	m4au_pkg::col_t                   out_res_q;
	logic                             out_sat_q;
	logic                             out_last_q;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign we_a       = accept && (opcode == m4au_pkg::OPC_LOAD_A);
	assign we_b       = accept && (opcode == m4au_pkg::OPC_LOAD_B);
	assign load_col   = {elem_three, elem_two, elem_one, elem_zero};

	assign multi_step = (op_q == m4au_pkg::OP_MATMUL) || (op_q == m4au_pkg::OP_MATVEC);
	assign step_last  = !multi_step || (k_q == m4au_pkg::IDX_W'(m4au_pkg::DIM - 1));
	assign run_last   = (op_q == m4au_pkg::OP_MATVEC) ||
		(col_q == m4au_pkg::IDX_W'(m4au_pkg::DIM - 1));

	assign a_raddr = multi_step ? k_q : col_q;
	assign b_raddr = ((op_q == m4au_pkg::OP_SCALE) || (op_q == m4au_pkg::OP_MATVEC)) ?
		'0 : col_q;

	always_comb begin
		ctl_s0.valid = (state_q == ST_ISSUE);
		ctl_s0.first = (k_q == '0);
		ctl_s0.last  = step_last;
		ctl_s0.k     = k_q;
		ctl_s0.op    = op_q;
	end

	m4au_ram #(
		.WIDTH(m4au_pkg::DIM * m4au_pkg::ELEM_W),
		.DEPTH(m4au_pkg::DIM)
	) u_store_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(column_index),
		.wdata(load_col),
		.raddr(a_raddr),
		.rdata(a_col)
	);

	m4au_ram #(
		.WIDTH(m4au_pkg::DIM * m4au_pkg::ELEM_W),
		.DEPTH(m4au_pkg::DIM)
	) u_store_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(column_index),
		.wdata(load_col),
		.raddr(b_raddr),
		.rdata(b_col)
	);

	m4au_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.a_col (a_col),
		.b_col (b_col),
		.ctl_s1(ctl_s1),
		.res   (mac_res),
		.sat   (mac_sat),
		.done  (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= m4au_pkg::OP_ADD;
			col_q       <= '0;
			k_q         <= '0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_s0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == m4au_pkg::OPC_RUN) &&
						(operation <= m4au_pkg::OP_MATVEC)) begin
						op_q    <= operation;
						col_q   <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (step_last) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!result_stall) begin
						out_valid_q <= 1'b0;
						k_q         <= '0;
						if (run_last) begin
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WAIT) && mac_done) begin
			out_col_q  <= col_q;
			out_res_q  <= mac_res;
			out_sat_q  <= mac_sat;
			out_last_q <= run_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign result_column = out_col_q;
	assign res_zero      = out_res_q[0];
	assign res_one       = out_res_q[1];
	assign res_two       = out_res_q[2];
	assign res_three     = out_res_q[3];
	assign saturated     = out_sat_q;
	assign last_column   = out_last_q;

endmodule
`default_nettype wire
